>>> src/iirs_pkg.sv
// Shared types and constants for the summed-area table block.
package iirs_pkg;

    localparam int SUM_BITS       = 28;
    localparam int PIX_BITS       = 16;
    localparam int COORD_BITS     = 6;
    localparam int DIM_REG_BITS   = 7;
    localparam int CFG_INDEX_BITS = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 4'd1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [DIM_REG_BITS-1:0] DIM_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_load;   // capture a load beat, advance the raster position
        logic accept_query;  // capture a query beat, read the first pair
        logic load_write;    // write the new table entry
        logic query_part;    // fold the first pair into the partial sum
        logic query_final;   // fold the second pair, load the result register
        logic rd_query;      // port A addresses the query corner from the input
        logic rd_held;       // both ports address the held left-hand pair
    } t_dp_cmd;

endpackage

>>> src/iirs_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
module iirs_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> src/iirs_ctrl.sv
// Controller: sequences loads and queries, owns the output valid flag.
module iirs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_command,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output iirs_pkg::t_dp_cmd o_cmd
);
    import iirs_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_QRY_A = 2'd2;
    localparam logic [1:0] S_QRY_B = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.rd_query = (i_command == CMD_QUERY);
                if (i_in_valid) begin
                    if (i_command == CMD_LOAD) begin
                        o_cmd.accept_load = 1'b1;
                        n_state           = S_LOAD;
                    end else begin
                        o_cmd.accept_query = 1'b1;
                        n_state            = S_QRY_A;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load_write = 1'b1;
                n_state          = S_IDLE;
            end
            S_QRY_A: begin
                o_cmd.rd_held    = 1'b1;
                o_cmd.query_part = 1'b1;
                n_state          = S_QRY_B;
            end
            S_QRY_B: begin
                // hold here while the previous result still waits
                o_cmd.rd_held = 1'b1;
                if (slot_free) begin
                    o_cmd.query_final = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && !i_out_ready) || o_cmd.query_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> src/iirs_dp.sv
// Datapath: grid registers, raster position, table memory and query arithmetic.
module iirs_dp #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  iirs_pkg::t_dp_cmd                   i_cmd,
    input  logic                                i_cfg_we,
    input  logic [iirs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [iirs_pkg::DIM_REG_BITS-1:0]   i_cfg_data,
    input  logic [iirs_pkg::PIX_BITS-1:0]       i_pixel_value,
    input  logic [iirs_pkg::COORD_BITS-1:0]     i_left_col,
    input  logic [iirs_pkg::COORD_BITS-1:0]     i_top_row,
    input  logic [iirs_pkg::COORD_BITS-1:0]     i_right_col,
    input  logic [iirs_pkg::COORD_BITS-1:0]     i_bottom_row,
    output logic [iirs_pkg::SUM_BITS-1:0]       o_rect_sum,
    output logic                                o_query_error
);
    import iirs_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int AW  = CW + RW;
    localparam int WDW = $clog2(MAX_WIDTH + 1);
    localparam int HDW = $clog2(MAX_HEIGHT + 1);
    localparam logic [PIX_BITS-1:0] PIX_MASK =
        (VALUE_BITS >= PIX_BITS) ? {PIX_BITS{1'b1}} : PIX_BITS'((64'd1 << VALUE_BITS) - 64'd1);

    function automatic int unsigned clamp_dim(input logic [DIM_REG_BITS-1:0] v,
                                              input int unsigned maxv);
        int unsigned d;
        d = 32'(v);
        if (d == 0) begin
            return 1;
        end
        return (d > maxv) ? maxv : d;
    endfunction

    // configuration and raster position
    logic [WDW-1:0]      r_width,  n_width;
    logic [HDW-1:0]      r_height, n_height;
    logic [CW-1:0]       r_col,    n_col;
    logic [RW-1:0]       r_row,    n_row;
    logic                r_ready,  n_ready;
    logic [SUM_BITS-1:0] r_rsum,   n_rsum;

    // held beat fields
    logic [AW-1:0]       r_wr_addr;
    logic                r_has_above;
    logic                r_err;
    logic                r_l_nz;
    logic                r_t_nz;
    logic [RW-1:0]       r_b;
    logic [CW-1:0]       r_lm1;
    logic [RW-1:0]       r_tm1;
    logic [SUM_BITS-1:0] r_part;
    logic [SUM_BITS-1:0] r_sum;
    logic                r_qerr;

    logic                pos_oob;
    logic [CW-1:0]       eff_col;
    logic [RW-1:0]       eff_row;
    logic [WDW-1:0]      col_inc;
    logic [HDW-1:0]      row_inc;
    logic [SUM_BITS-1:0] pix_ext;
    logic                q_err;
    logic [SUM_BITS-1:0] final_sum;

    logic [AW-1:0]       raddr_a;
    logic [AW-1:0]       raddr_b;
    logic [SUM_BITS-1:0] rdata_a;
    logic [SUM_BITS-1:0] rdata_b;
    logic [SUM_BITS-1:0] wdata;

    assign pos_oob = (WDW'(r_col) >= r_width) || (HDW'(r_row) >= r_height);
    assign eff_col = pos_oob ? '0 : r_col;
    assign eff_row = pos_oob ? '0 : r_row;
    assign col_inc = WDW'(eff_col) + WDW'(1);
    assign row_inc = HDW'(eff_row) + HDW'(1);
    assign pix_ext = SUM_BITS'(i_pixel_value & PIX_MASK);

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_row    = r_row;
        n_ready  = r_ready;
        n_rsum   = r_rsum;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_WIDTH: begin
                    n_width = WDW'(clamp_dim(i_cfg_data, MAX_WIDTH));
                    n_col   = '0;
                    n_row   = '0;
                    n_ready = 1'b0;
                    n_rsum  = '0;
                end
                REG_GRID_HEIGHT: begin
                    n_height = HDW'(clamp_dim(i_cfg_data, MAX_HEIGHT));
                    n_col    = '0;
                    n_row    = '0;
                    n_ready  = 1'b0;
                    n_rsum   = '0;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.accept_load) begin
            n_rsum = (eff_col == '0) ? pix_ext : r_rsum + pix_ext;
            if ((eff_col == '0) && (eff_row == '0)) begin
                n_ready = 1'b0;
            end
            if (col_inc >= r_width) begin
                n_col = '0;
                if (row_inc >= r_height) begin
                    n_row   = '0;
                    n_ready = 1'b1;
                end else begin
                    n_row = RW'(row_inc);
                end
            end else begin
                n_col = CW'(col_inc);
                n_row = eff_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WDW'(clamp_dim(DIM_RESET, MAX_WIDTH));
            r_height <= HDW'(clamp_dim(DIM_RESET, MAX_HEIGHT));
            r_col    <= '0;
            r_row    <= '0;
            r_ready  <= 1'b0;
            r_rsum   <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_ready  <= n_ready;
            r_rsum   <= n_rsum;
        end
    end

    assign q_err = !r_ready || (i_left_col > i_right_col) || (i_top_row > i_bottom_row)
                || (32'(i_right_col) >= 32'(r_width))
                || (32'(i_bottom_row) >= 32'(r_height));

    assign final_sum = r_part - (r_l_nz ? rdata_a : '0)
                     + ((r_l_nz && r_t_nz) ? rdata_b : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_load) begin
            r_wr_addr   <= {eff_row, eff_col};
            r_has_above <= (eff_row != '0);
        end
        if (i_cmd.accept_query) begin
            r_err  <= q_err;
            r_l_nz <= (i_left_col != '0);
            r_t_nz <= (i_top_row != '0);
            r_b    <= RW'(i_bottom_row);
            r_lm1  <= CW'(i_left_col - COORD_BITS'(1));
            r_tm1  <= RW'(i_top_row - COORD_BITS'(1));
        end
        if (i_cmd.query_part) begin
            r_part <= rdata_a - (r_t_nz ? rdata_b : '0);
        end
        if (i_cmd.query_final) begin
            r_sum  <= r_err ? '0 : final_sum;
            r_qerr <= r_err;
        end
    end

    // port A: entry above the load, bottom-right corner, or bottom-left corner
    always_comb begin
        if (i_cmd.rd_held) begin
            raddr_a = {r_b, r_lm1};
            raddr_b = {r_tm1, r_lm1};
        end else begin
            raddr_a = i_cmd.rd_query ? {RW'(i_bottom_row), CW'(i_right_col)}
                                     : {eff_row - RW'(1), eff_col};
            raddr_b = {RW'(i_top_row - COORD_BITS'(1)), CW'(i_right_col)};
        end
    end

    assign wdata = r_rsum + (r_has_above ? rdata_a : '0);

    iirs_ram #(
        .WIDTH(SUM_BITS),
        .DEPTH(1 << AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_we     (i_cmd.load_write),
        .i_waddr  (r_wr_addr),
        .i_wdata  (wdata),
        .i_raddr_a(raddr_a),
        .i_raddr_b(raddr_b),
        .o_rdata_a(rdata_a),
        .o_rdata_b(rdata_b)
    );

    assign o_rect_sum    = r_sum;
    assign o_query_error = r_qerr;

endmodule

>>> src/integral_image_rect_sum.sv
// Top level: summed-area table builder with rectangle-sum queries.
//
//  channel  | beat signals                          | payload
//  ---------+---------------------------------------+-------------------------------------
//  input    | i_in_valid  / o_in_ready              | command, pixel_value, rectangle
//  output   | o_out_valid / i_out_ready             | rect_sum, query_error
//  config   | i_cfg_valid / o_cfg_ready (always 1)  | i_cfg_index, i_cfg_data
//
// A load beat holds the input while the block reads the entry above, then writes.
// A query beat holds it while the block reads four entries two at a time, then
// loads the result register, and longer while an earlier result waits on the output.
// A load produces no output beat; every query produces exactly one.
// Synchronous active-low reset restores a 64 x 64 grid (clamped to the
// parameters) and marks the table not ready; the memory itself is not cleared.
module integral_image_rect_sum #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input beats
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_command,
    input  logic [iirs_pkg::PIX_BITS-1:0]       i_pixel_value,
    input  logic [iirs_pkg::COORD_BITS-1:0]     i_left_col,
    input  logic [iirs_pkg::COORD_BITS-1:0]     i_top_row,
    input  logic [iirs_pkg::COORD_BITS-1:0]     i_right_col,
    input  logic [iirs_pkg::COORD_BITS-1:0]     i_bottom_row,
    // output beats
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [iirs_pkg::SUM_BITS-1:0]       o_rect_sum,
    output logic                                o_query_error,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [iirs_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [iirs_pkg::DIM_REG_BITS-1:0]   i_cfg_data
);
    import iirs_pkg::*;

    t_dp_cmd dp_cmd;

    // Register writes must land only while the block is idle; the block does not enforce this and takes them at once.
    assign o_cfg_ready = 1'b1;

    iirs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .i_out_ready(i_out_ready),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the grid size, the raster position, the running
    // row sum, the table memory and the result register.
    iirs_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_pixel_value(i_pixel_value),
        .i_left_col   (i_left_col),
        .i_top_row    (i_top_row),
        .i_right_col  (i_right_col),
        .i_bottom_row (i_bottom_row),
        .o_rect_sum   (o_rect_sum),
        .o_query_error(o_query_error)
    );

endmodule

>>> src/iirs_checker.sv
// Port-level checks for the summed-area table block, bound to the top level.
module iirs_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input logic                                i_command,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [iirs_pkg::SUM_BITS-1:0]       o_rect_sum,
    input logic                                o_query_error
);
    import iirs_pkg::*;

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // a load keeps the input closed through S_LOAD, while the table is written
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_command == CMD_LOAD) |=> !o_in_ready)
        else $error("input accepted during a table write");

    // a query keeps the input closed through S_QRY_A and S_QRY_B
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && (i_command == CMD_QUERY) |=> !o_in_ready ##1 !o_in_ready)
        else $error("input accepted during a query");

    // an error result carries a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_query_error |-> (o_rect_sum == '0))
        else $error("error result with nonzero sum");

endmodule

bind integral_image_rect_sum iirs_checker u_iirs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_command    (i_command),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_rect_sum   (o_rect_sum),
    .o_query_error(o_query_error)
);

>>> test/tb_integral_image_rect_sum.sv
// Self-checking testbench for the summed-area table block and its rectangle-sum queries.
`timescale 1ns / 100ps

module tb_integral_image_rect_sum;
    import iirs_pkg::*;

    localparam int GRID_MAX_W   = 64;
    localparam int GRID_MAX_H   = 64;
    localparam int RANDOM_ITEMS = 220;
    // Cycles to let a load finish its table write before a register write.
    localparam int DRAIN_CYCLES = 8;

    // One input beat: command plus every payload field.
    typedef struct packed {
        logic                  cmd;
        logic [PIX_BITS-1:0]   pix;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } t_grid_beat;

    // One result beat as the table predicts it.
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                err;
    } t_rect_answer;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_ready;
    t_grid_beat                beat_on_bus    = '0;
    wire                       i_command      = beat_on_bus.cmd;
    wire  [PIX_BITS-1:0]       i_pixel_value  = beat_on_bus.pix;
    wire  [COORD_BITS-1:0]     i_left_col     = beat_on_bus.left;
    wire  [COORD_BITS-1:0]     i_top_row      = beat_on_bus.top;
    wire  [COORD_BITS-1:0]     i_right_col    = beat_on_bus.right;
    wire  [COORD_BITS-1:0]     i_bottom_row   = beat_on_bus.bottom;
    logic                      o_out_valid;
    logic                      i_out_ready    = 1'b0;
    logic [SUM_BITS-1:0]       o_rect_sum;
    logic                      o_query_error;
    logic                      i_cfg_valid    = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index    = '0;
    logic [DIM_REG_BITS-1:0]   i_cfg_data     = '0;

    integral_image_rect_sum #(
        .MAX_WIDTH  (GRID_MAX_W),
        .MAX_HEIGHT (GRID_MAX_H),
        .VALUE_BITS (PIX_BITS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_pixel_value (i_pixel_value),
        .i_left_col    (i_left_col),
        .i_top_row     (i_top_row),
        .i_right_col   (i_right_col),
        .i_bottom_row  (i_bottom_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rect_sum    (o_rect_sum),
        .o_query_error (o_query_error),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Table predictor: its own copy of the grid size, raster position and
    // summed-area entries, advanced once per accepted load beat.
    // ------------------------------------------------------------------
    logic [DIM_REG_BITS-1:0] grid_w_reg  = DIM_RESET;
    logic [DIM_REG_BITS-1:0] grid_h_reg  = DIM_RESET;
    logic [SUM_BITS-1:0]     sat [GRID_MAX_W*GRID_MAX_H];
    logic [21:0]             row_acc     = '0;
    int unsigned             load_col    = 0;
    int unsigned             load_row    = 0;
    bit                      table_valid = 1'b0;

    t_grid_beat   beats_to_send[$];
    t_rect_answer answers_due[$];

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned n_loads        = 0;
    int unsigned n_queries      = 0;
    int unsigned n_err_queries  = 0;
    int unsigned n_reg_writes   = 0;
    int unsigned n_fail         = 0;

    // A zero size acts as one, anything past the maximum as the maximum.
    function automatic int unsigned dim_in_use(logic [DIM_REG_BITS-1:0] v, int unsigned mx);
        if (v == 0)
            return 1;
        return (32'(v) > mx) ? mx : 32'(v);
    endfunction

    function automatic void sat_restart();
        load_col    = 0;
        load_row    = 0;
        row_acc     = '0;
        table_valid = 1'b0;
    endfunction

    function automatic void sat_load(logic [PIX_BITS-1:0] pix);
        int unsigned         w;
        int unsigned         h;
        logic [SUM_BITS-1:0] above;
        w = dim_in_use(grid_w_reg, GRID_MAX_W);
        h = dim_in_use(grid_h_reg, GRID_MAX_H);
        // Position zero starts a new image.
        if (load_col == 0 && load_row == 0)
            table_valid = 1'b0;
        if (load_col >= w || load_row >= h)
            sat_restart();
        if (load_col == 0)
            row_acc = 22'(pix);
        else
            row_acc = row_acc + 22'(pix);
        above = (load_row > 0) ? sat[(load_row - 1) * GRID_MAX_W + load_col] : '0;
        sat[load_row * GRID_MAX_W + load_col] = SUM_BITS'(row_acc) + above;
        load_col++;
        if (load_col >= w) begin
            load_col = 0;
            load_row++;
            if (load_row >= h) begin
                load_row    = 0;
                table_valid = 1'b1;
            end
        end
    endfunction

    function automatic t_rect_answer sat_query(t_grid_beat bt);
        int unsigned         w;
        int unsigned         h;
        int unsigned         l;
        int unsigned         t;
        int unsigned         r;
        int unsigned         b;
        logic [SUM_BITS-1:0] s;
        t_rect_answer        ans;
        w = dim_in_use(grid_w_reg, GRID_MAX_W);
        h = dim_in_use(grid_h_reg, GRID_MAX_H);
        l = 32'(bt.left);
        t = 32'(bt.top);
        r = 32'(bt.right);
        b = 32'(bt.bottom);
        ans.sum = '0;
        ans.err = 1'b1;
        if (!table_valid || l > r || t > b || r >= w || b >= h)
            return ans;
        // Row -1 and column -1 read as zero, so drop those corner terms.
        s = sat[b * GRID_MAX_W + r];
        if (t != 0)
            s = s - sat[(t - 1) * GRID_MAX_W + r];
        if (l != 0)
            s = s - sat[b * GRID_MAX_W + l - 1];
        if (l != 0 && t != 0)
            s = s + sat[(t - 1) * GRID_MAX_W + l - 1];
        ans.sum = s;
        ans.err = 1'b0;
        return ans;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next pending beat, hold it until accepted, and
    // predict each beat at the edge that accepts it. Also throttle the
    // output side.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_beats
        t_grid_beat   nxt;
        t_rect_answer ans;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (i_in_valid && o_in_ready) begin
                if (beat_on_bus.cmd == CMD_LOAD) begin
                    sat_load(beat_on_bus.pix);
                    n_loads++;
                end else begin
                    ans = sat_query(beat_on_bus);
                    answers_due.insert(answers_due.size(), ans);
                    n_queries++;
                    if (ans.err)
                        n_err_queries++;
                end
            end
            // The bus is free when nothing is offered or the offer just went through.
            if (!i_in_valid || o_in_ready) begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    nxt = beats_to_send.pop_front();
                    beat_on_bus <= nxt;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid  <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat with the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_rect_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                $error("result beat with no query pending: rect_sum %0d query_error %0b",
                       o_rect_sum, o_query_error);
                n_fail++;
            end else begin
                want = answers_due.pop_front();
                if (o_rect_sum !== want.sum) begin
                    $error("rect_sum: expected %0d, got %0d", want.sum, o_rect_sum);
                    n_fail++;
                end
                if (o_query_error !== want.err) begin
                    $error("query_error: expected %0b, got %0b", want.err, o_query_error);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic void queue_load(logic [PIX_BITS-1:0] pix);
        t_grid_beat bt;
        // Rectangle fields are don't-care on a load; randomize them anyway.
        bt.cmd    = CMD_LOAD;
        bt.pix    = pix;
        bt.left   = COORD_BITS'($urandom_range(63));
        bt.top    = COORD_BITS'($urandom_range(63));
        bt.right  = COORD_BITS'($urandom_range(63));
        bt.bottom = COORD_BITS'($urandom_range(63));
        beats_to_send.insert(beats_to_send.size(), bt);
    endfunction

    function automatic void queue_query(logic [COORD_BITS-1:0] l, logic [COORD_BITS-1:0] t,
                                        logic [COORD_BITS-1:0] r, logic [COORD_BITS-1:0] b);
        t_grid_beat bt;
        bt.cmd    = CMD_QUERY;
        bt.pix    = PIX_BITS'($urandom_range(16'hFFFF));
        bt.left   = l;
        bt.top    = t;
        bt.right  = r;
        bt.bottom = b;
        beats_to_send.insert(beats_to_send.size(), bt);
    endfunction

    function automatic void queue_stray_query();
        queue_query(COORD_BITS'($urandom_range(63)), COORD_BITS'($urandom_range(63)),
                    COORD_BITS'($urandom_range(63)), COORD_BITS'($urandom_range(63)));
    endfunction

    // Hold until every queued beat is accepted and every result has come back.
    // Sample on the falling edge so the driver's updates have settled.
    task automatic wait_results_drained();
        while (beats_to_send.size() != 0 || i_in_valid || answers_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Drain, then give the last load time to land before touching registers.
    task automatic settle_idle();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [DIM_REG_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        // Either size register restarts the raster load; other indexes do nothing.
        if (idx == REG_GRID_WIDTH) begin
            grid_w_reg = val;
            sat_restart();
        end else if (idx == REG_GRID_HEIGHT) begin
            grid_h_reg = val;
            sat_restart();
        end
        n_reg_writes++;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int unsigned pick_dim();
        return ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: directed corners first, then random image/query phases.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned l;
        int unsigned t;
        int unsigned r;
        int unsigned b;
        int unsigned choice;
        int unsigned rnd_items;
        bit          held_once;
        rnd_items = 0;
        held_once = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_gap_pct   = 29;
        recv_stall_pct = 79;
        @(negedge i_clk);

        // No image loaded yet: error.
        queue_query(0, 0, 0, 0);
        settle_idle();

        // 2x2 image with extreme values; query before and after it completes.
        write_reg(REG_GRID_WIDTH, 7'd2);
        write_reg(REG_GRID_HEIGHT, 7'd2);
        queue_load(16'hFFFF);
        queue_load(16'h0000);
        queue_query(0, 0, 1, 0);
        queue_load(16'h0001);
        queue_load(16'hFFFF);
        queue_query(0, 0, 1, 1);
        queue_query(1, 1, 1, 1);
        queue_query(1, 0, 1, 1);
        queue_query(0, 1, 1, 1);
        queue_query(0, 0, 0, 0);
        queue_query(1, 0, 0, 0);
        queue_query(0, 1, 0, 0);
        queue_query(0, 0, 2, 0);
        queue_query(0, 0, 0, 2);
        queue_query(63, 63, 63, 63);
        settle_idle();

        // An index past the size registers leaves the finished image usable.
        write_reg(4'hF, 7'h7F);
        queue_query(0, 0, 1, 1);
        // A load after a complete image starts a new one.
        queue_load(16'h1234);
        queue_query(0, 0, 0, 0);
        settle_idle();

        // Width 0 acts as 1, height 127 as the maximum.
        write_reg(REG_GRID_WIDTH, 7'd0);
        write_reg(REG_GRID_HEIGHT, 7'h7F);
        repeat (GRID_MAX_H) queue_load(PIX_BITS'($urandom_range(16'hFFFF)));
        queue_query(0, 0, 0, 63);
        queue_query(0, 10, 0, 40);
        queue_query(1, 0, 1, 0);
        settle_idle();

        // Two full-width rows of the largest value.
        write_reg(REG_GRID_WIDTH, 7'd64);
        write_reg(REG_GRID_HEIGHT, 7'd2);
        repeat (2 * GRID_MAX_W) queue_load(16'hFFFF);
        queue_query(0, 0, 63, 1);
        queue_query(63, 1, 63, 1);
        queue_query(1, 1, 62, 1);
        queue_query(0, 1, 63, 1);
        queue_query(0, 0, 63, 2);
        settle_idle();

        // Single full-width row.
        write_reg(REG_GRID_HEIGHT, 7'd1);
        repeat (GRID_MAX_W) queue_load(PIX_BITS'($urandom_range(16'hFFFF)));
        queue_query(0, 0, 63, 0);
        queue_query(5, 0, 40, 0);

        // Random phases: mostly full images followed by in-range queries,
        // with cut-short loads, stray queries and bad rectangles as noise.
        while (rnd_items < RANDOM_ITEMS) begin
            if (rnd_items < RANDOM_ITEMS / 3) begin
                send_gap_pct   = 29;
                recv_stall_pct = 79;
            end else if (rnd_items < 2 * RANDOM_ITEMS / 3) begin
                send_gap_pct   = 79;
                recv_stall_pct = 29;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            choice = $urandom_range(99);
            if (choice < 60) begin
                settle_idle();
                if ($urandom_range(9) == 0) begin
                    write_reg(CFG_INDEX_BITS'($urandom_range(15, 2)),
                              DIM_REG_BITS'($urandom_range(127)));
                end else begin
                    w = pick_dim();
                    h = pick_dim();
                    write_reg(REG_GRID_WIDTH,
                              DIM_REG_BITS'(($urandom_range(19) == 0) ? 0 : w));
                    write_reg(REG_GRID_HEIGHT, DIM_REG_BITS'(h));
                end
            end
            w = dim_in_use(grid_w_reg, GRID_MAX_W);
            h = dim_in_use(grid_h_reg, GRID_MAX_H);
            if (choice < 90) begin
                n = w * h;
                if ($urandom_range(9) == 0)
                    n = $urandom_range(n - 1);
                repeat (n) begin
                    queue_load(PIX_BITS'($urandom_range(16'hFFFF)));
                    rnd_items++;
                    if ($urandom_range(99) < 3) begin
                        queue_stray_query();
                        rnd_items++;
                    end
                end
            end
            repeat ($urandom_range(8, 2)) begin
                if ($urandom_range(4) != 0) begin
                    l = $urandom_range(w - 1);
                    r = $urandom_range(w - 1, l);
                    t = $urandom_range(h - 1);
                    b = $urandom_range(h - 1, t);
                    queue_query(COORD_BITS'(l), COORD_BITS'(t), COORD_BITS'(r), COORD_BITS'(b));
                end else begin
                    queue_stray_query();
                end
                rnd_items++;
            end
            // Stop sending once midway until the output side has caught up.
            if (!held_once && rnd_items >= RANDOM_ITEMS / 2) begin
                wait_results_drained();
                held_once = 1'b1;
            end
        end

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d loads, %0d queries (%0d flagged as errors), %0d register writes",
                 n_loads, n_queries, n_err_queries, n_reg_writes);
        $display("grids from 1x1 up to 64 columns or 64 rows, three handshake throttling regimes");
        if (n_fail == 0)
            $display("integral_image_rect_sum regression: pass");
        else
            $display("integral_image_rect_sum regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #4_000_000;
        $display("integral_image_rect_sum regression: fail");
        $finish;
    end

endmodule
